// ----- rtl/tfn_pkg.sv -----
`timescale 1ns / 1ps

package tfn_pkg;

    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int OUT_BITS = NORMAL_FRAC_BITS + 2;
    localparam int EDGE_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = 2 * COORD_BITS + 2;
    localparam int LO_W     = (MAG_W + 1) / 2;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int SUM_W    = 4 * COORD_BITS + 4;
    localparam int Q_W      = NORMAL_FRAC_BITS + 1;
    localparam int ACC_W    = SUM_W + NORMAL_FRAC_BITS + 1;
    localparam int RES_W    = 4 * COORD_BITS + 2 * NORMAL_FRAC_BITS + 9;

    // front pipeline depth, one cell per result bit, output register
    localparam int FRONT_STAGES = 6;
    localparam int LATENCY      = FRONT_STAGES + Q_W + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] normal_x;
        logic signed [OUT_BITS-1:0] normal_y;
        logic signed [OUT_BITS-1:0] normal_z;
        logic                       degenerate;
    } t_normal_out;

    // one component's search state: rem = M - (2q-1)^2 S, acc = q S
    typedef struct packed {
        logic [RES_W-1:0] rem;
        logic [ACC_W-1:0] acc;
        logic [Q_W-1:0]   q;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]      lane;
        logic [SUM_W-1:0] sum;
    } t_cell_word;

endpackage

// ----- rtl/tfn_front.sv -----
`timescale 1ns / 1ps

module tfn_front import tfn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_tri_in    i_tri,
    output logic       o_valid,
    output t_cell_word o_word
);

    logic [FRONT_STAGES-1:0] r_valid;

    logic signed [EDGE_W-1:0]  r_k [3];
    logic signed [EDGE_W-1:0]  r_l [3];
    logic signed [PROD_W-1:0]  r_pa [3];
    logic signed [PROD_W-1:0]  r_pb [3];
    logic [MAG_W-1:0]          r_mag [3];
    logic [2:0]                r_neg3;
    logic [2*LO_W-1:0]         r_ll [3];
    logic [LO_W+HI_W-1:0]      r_lh [3];
    logic [2*HI_W-1:0]         r_hh [3];
    logic [2:0]                r_neg4;
    logic [SUM_W-1:0]          r_sq [3];
    logic [SUM_W-1:0]          r_sum;
    logic [2:0]                r_neg5;
    t_cell_word                r_word;

    logic signed [CROSS_W-1:0] n_cross [3];
    logic [CROSS_W-1:0]        n_abs [3];
    logic [SUM_W-1:0]          n_sq [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cross[i] = CROSS_W'(r_pa[i]) - CROSS_W'(r_pb[i]);
            n_abs[i]   = n_cross[i][CROSS_W-1] ? -n_cross[i] : n_cross[i];
            n_sq[i]    = (SUM_W'(r_hh[i]) << (2 * LO_W))
                       + (SUM_W'(r_lh[i]) << (LO_W + 1))
                       + SUM_W'(r_ll[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // edges from the first vertex
        r_k[0] <= EDGE_W'(i_tri.b_x) - EDGE_W'(i_tri.a_x);
        r_k[1] <= EDGE_W'(i_tri.b_y) - EDGE_W'(i_tri.a_y);
        r_k[2] <= EDGE_W'(i_tri.b_z) - EDGE_W'(i_tri.a_z);
        r_l[0] <= EDGE_W'(i_tri.c_x) - EDGE_W'(i_tri.a_x);
        r_l[1] <= EDGE_W'(i_tri.c_y) - EDGE_W'(i_tri.a_y);
        r_l[2] <= EDGE_W'(i_tri.c_z) - EDGE_W'(i_tri.a_z);

        r_pa[0] <= r_k[1] * r_l[2];
        r_pb[0] <= r_k[2] * r_l[1];
        r_pa[1] <= r_k[2] * r_l[0];
        r_pb[1] <= r_k[0] * r_l[2];
        r_pa[2] <= r_k[0] * r_l[1];
        r_pb[2] <= r_k[1] * r_l[0];

        for (int i = 0; i < 3; i++) begin
            r_mag[i]  <= n_abs[i][MAG_W-1:0];
            r_neg3[i] <= n_cross[i][CROSS_W-1];
        end

        // square split in halves
        for (int i = 0; i < 3; i++) begin
            r_ll[i] <= r_mag[i][LO_W-1:0] * r_mag[i][LO_W-1:0];
            r_lh[i] <= r_mag[i][LO_W-1:0] * r_mag[i][MAG_W-1:LO_W];
            r_hh[i] <= r_mag[i][MAG_W-1:LO_W] * r_mag[i][MAG_W-1:LO_W];
        end
        r_neg4 <= r_neg3;

        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= n_sq[i];
        end
        r_sum  <= n_sq[0] + n_sq[1] + n_sq[2];
        r_neg5 <= r_neg4;

        for (int i = 0; i < 3; i++) begin
            r_word.lane[i].rem <= (RES_W'(r_sq[i]) << (2 * NORMAL_FRAC_BITS + 2))
                                - RES_W'(r_sum);
            r_word.lane[i].acc <= '0;
            r_word.lane[i].q   <= '0;
            r_word.lane[i].neg <= r_neg5[i];
        end
        r_word.sum <= r_sum;
    end

    assign o_valid = r_valid[FRONT_STAGES-1];
    assign o_word  = r_word;

endmodule

// ----- rtl/tfn_cell.sv -----
`timescale 1ns / 1ps

module tfn_cell import tfn_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_word i_word,
    output logic       o_valid,
    output t_cell_word o_word
);

    logic       r_valid;
    t_cell_word r_word;
    t_cell_word n_word;

    logic [RES_W-1:0] trial [3];

    // (2q+2b-1)^2 S = (2q-1)^2 S + 8b qS - 4b S + 4b^2 S
    always_comb begin
        n_word = i_word;
        for (int i = 0; i < 3; i++) begin
            trial[i] = i_word.lane[i].rem
                     - (RES_W'(i_word.lane[i].acc) << (BIT + 3))
                     + (RES_W'(i_word.sum) << (BIT + 2))
                     - (RES_W'(i_word.sum) << (2 * BIT + 2));
            if (!trial[i][RES_W-1]) begin
                n_word.lane[i].rem = trial[i];
                n_word.lane[i].acc = i_word.lane[i].acc + (ACC_W'(i_word.sum) << BIT);
                n_word.lane[i].q   = i_word.lane[i].q | (Q_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/triangle_face_normal_core.sv -----
`timescale 1ns / 1ps

// Triangle face normal: one triangle is taken in every clock and its unit
// normal comes out on o_strobe for a single cycle. The pipeline is the edge,
// cross product and squaring front, one cell per result bit that decides
// that bit for all three components, and the output register. busy is
// always low and the receiver cannot stall, so results must be taken as
// they come.

module triangle_face_normal_core import tfn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_tri_in     i_tri,
    output logic        o_strobe,
    output t_normal_out o_result
);

    logic       chain_valid [Q_W+1];
    t_cell_word chain_word  [Q_W+1];

    logic        r_strobe;
    t_normal_out r_result;
    t_normal_out n_result;
    logic        last_zero;

    assign busy = 1'b0;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_tri   (i_tri),
        .o_valid (chain_valid[0]),
        .o_word  (chain_word[0])
    );

    // most significant bit first
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        tfn_cell #(
            .BIT (NORMAL_FRAC_BITS - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_word  (chain_word[g]),
            .o_valid (chain_valid[g+1]),
            .o_word  (chain_word[g+1])
        );
    end

    always_comb begin
        last_zero = (chain_word[Q_W].sum == '0);
        if (last_zero) begin
            n_result.normal_x = '0;
            n_result.normal_y = '0;
            n_result.normal_z = '0;
        end else begin
            n_result.normal_x = chain_word[Q_W].lane[0].neg
                              ? -OUT_BITS'(chain_word[Q_W].lane[0].q)
                              : OUT_BITS'(chain_word[Q_W].lane[0].q);
            n_result.normal_y = chain_word[Q_W].lane[1].neg
                              ? -OUT_BITS'(chain_word[Q_W].lane[1].q)
                              : OUT_BITS'(chain_word[Q_W].lane[1].q);
            n_result.normal_z = chain_word[Q_W].lane[2].neg
                              ? -OUT_BITS'(chain_word[Q_W].lane[2].q)
                              : OUT_BITS'(chain_word[Q_W].lane[2].q);
        end
        n_result.degenerate = last_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= chain_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/tfn_checker.sv -----
`timescale 1ns / 1ps

module tfn_assertions import tfn_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input t_normal_out o_result
);

    localparam logic signed [OUT_BITS-1:0] ONE = OUT_BITS'(1) << NORMAL_FRAC_BITS;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("word accepted but no result after fixed latency");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.degenerate) |->
            (o_result.normal_x == '0 && o_result.normal_y == '0
             && o_result.normal_z == '0))
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            (o_result.normal_x <= ONE && o_result.normal_x >= -ONE
             && o_result.normal_y <= ONE && o_result.normal_y >= -ONE
             && o_result.normal_z <= ONE && o_result.normal_z >= -ONE))
        else $error("normal component beyond one");

endmodule

bind triangle_face_normal_core tfn_assertions u_tfn_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- bench/tfn_checker.sv -----
`timescale 1ns / 1ps

module tfn_checker import tfn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_tri_in     i_tri,
    input  logic        o_strobe,
    input  t_normal_out o_result,
    output int          errors,
    output int          pending
);

    t_normal_out normals_due[$];

    // exact cross product, then per component the rounded quotient found by bisection
    function automatic t_normal_out unit_normal(t_tri_in t);
        logic signed [63:0] ax, ay, az, kx, ky, kz, lx, ly, lz, tmp;
        logic signed [63:0] cr[3];
        logic [191:0]       mag[3];
        logic [191:0]       sum, rhs, lhs;
        logic [63:0]        lo, hi, mid, odd;
        logic [OUT_BITS-1:0] comp[3];
        t_normal_out        r;
        ax = t.a_x; ay = t.a_y; az = t.a_z;
        tmp = t.b_x; kx = tmp - ax;
        tmp = t.b_y; ky = tmp - ay;
        tmp = t.b_z; kz = tmp - az;
        tmp = t.c_x; lx = tmp - ax;
        tmp = t.c_y; ly = tmp - ay;
        tmp = t.c_z; lz = tmp - az;
        cr[0] = ky * lz - kz * ly;
        cr[1] = kz * lx - kx * lz;
        cr[2] = kx * ly - ky * lx;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? 192'(-cr[i]) : 192'(cr[i]);
            sum += mag[i] * mag[i];
        end
        r = '0;
        if (sum == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            rhs = (mag[i] * mag[i]) << (2 * NORMAL_FRAC_BITS + 2);
            lo = 0;
            hi = 64'd1 << NORMAL_FRAC_BITS;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                odd = 2 * mid - 1;
                lhs = 192'(odd * odd) * sum;
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            comp[i] = (cr[i] < 0) ? OUT_BITS'(-lo) : OUT_BITS'(lo);
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        return r;
    endfunction

    assign pending = normals_due.size();

    always @(posedge i_clk) begin
        t_normal_out want;
        if (!i_rst_n) begin
            errors <= 0;
        end else begin
            if (o_strobe) begin
                if (normals_due.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, o_result);
                    errors <= errors + 1;
                end else begin
                    want = normals_due.pop_front();
                    if (o_result !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_result);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                normals_due.push_back(unit_normal(i_tri));
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tfn_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_tri_in     i_tri = '0;
    logic        o_strobe;
    t_normal_out o_result;
    int          errors;
    int          pending;
    int          idle_pct = 0;
    int          quiet_cycles = 0;

    triangle_face_normal_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_tri(i_tri), .o_strobe(o_strobe), .o_result(o_result)
    );

    tfn_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_tri(i_tri), .o_strobe(o_strobe), .o_result(o_result),
        .errors(errors), .pending(pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("triangle_face_normal_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tri(input t_tri_in t);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_tri <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic t_tri_in make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz);
        t_tri_in t;
        t.a_x = COORD_BITS'(ax); t.a_y = COORD_BITS'(ay); t.a_z = COORD_BITS'(az);
        t.b_x = COORD_BITS'(bx); t.b_y = COORD_BITS'(by); t.b_z = COORD_BITS'(bz);
        t.c_x = COORD_BITS'(cx); t.c_y = COORD_BITS'(cy); t.c_z = COORD_BITS'(cz);
        return t;
    endfunction

    function automatic int near_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    initial begin
        t_tri_in t;
        int      mode;
        int      dx, dy, dz;
        int      mx, mn;
        mx = (1 << (COORD_BITS - 1)) - 1;
        mn = -(1 << (COORD_BITS - 1));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate: all zero, repeated vertex, collinear
        send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(make_tri(5, 6, 7, 5, 6, 7, 9, 1, 2));
        send_tri(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6));
        send_tri(make_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0));
        // axis-aligned faces, both windings
        send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_tri(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
        send_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        send_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        send_tri(make_tri(0, 0, 0, 0, 0, -1, 0, 1, 0));
        // diagonal normal, rounding near ties
        send_tri(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 5));
        // full-range edges
        send_tri(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
        send_tri(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
        send_tri(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
        send_tri(make_tri(mx, mn, mx, mn, mn, mn, mx, mx, mn));
        send_tri(make_tri(mn, 0, mx, mx, mn, 0, 0, mx, mn));
        send_tri(make_tri(-1, -1, -1, mx, 0, 0, 0, mn, 1));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 49;
                2: idle_pct = 36;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 500; n++) begin
                mode = $urandom_range(0, 9);
                if (mode < 5) begin
                    t = t_tri_in'((9 * COORD_BITS)'({$urandom, $urandom, $urandom,
                                                     $urandom, $urandom, $urandom,
                                                     $urandom}));
                end else if (mode < 8) begin
                    t = make_tri(near_coord(8), near_coord(8), near_coord(8),
                                 near_coord(8), near_coord(8), near_coord(8),
                                 near_coord(8), near_coord(8), near_coord(8));
                end else begin
                    // collinear vertices give a zero cross product
                    dx = near_coord(1000); dy = near_coord(1000); dz = near_coord(1000);
                    t = make_tri(near_coord(100000), near_coord(100000), near_coord(100000),
                                 0, 0, 0, 0, 0, 0);
                    t.b_x = t.a_x + COORD_BITS'(dx);
                    t.b_y = t.a_y + COORD_BITS'(dy);
                    t.b_z = t.a_z + COORD_BITS'(dz);
                    t.c_x = t.a_x - COORD_BITS'(3 * dx);
                    t.c_y = t.a_y - COORD_BITS'(3 * dy);
                    t.c_z = t.a_z - COORD_BITS'(3 * dz);
                end
                send_tri(t);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0)
            $display("triangle_face_normal_core verification clean");
        else
            $display("triangle_face_normal_core verification failed");
        $finish;
    end

endmodule
